### hdl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Needs nothing else; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Same check with a fixed message for handshake rules.
`define ASSERT_HS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("handshake rule broken");

`endif

### hdl/opc_pkg.sv
// Types and constants of the obstruction pulse classifier.
// Used by the core, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package opc_pkg;

	// Item function codes
	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_ROSE = 2'd1;
	localparam logic [1:0] FUNC_FELL = 2'd2;

	// Beam status codes
	localparam logic [1:0] STAT_OBSTRUCTED = 2'd0;
	localparam logic [1:0] STAT_CLEAR      = 2'd1;
	localparam logic [1:0] STAT_UNKNOWN    = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_WINDOW_MS    = 2'd0;
	localparam logic [1:0] REG_MIN_PULSES   = 2'd1;
	localparam logic [1:0] REG_MAX_PULSES   = 2'd2;
	localparam logic [1:0] REG_HIGH_TIMEOUT = 2'd3;

	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic [7:0]  RST_WINDOW_MS    = 8'd25;
	localparam logic [7:0]  RST_MIN_PULSES   = 8'd3;
	localparam logic [7:0]  RST_MAX_PULSES   = 8'd5;
	localparam logic [15:0] RST_HIGH_TIMEOUT = 16'd50;

	localparam logic [7:0] PULSE_MAX = 8'hFF;

	typedef struct packed {
		logic [1:0] func;
		logic       line_level;
	} opc_in_t;

	typedef struct packed {
		logic [1:0] beam_status;
		logic       status_changed;
	} opc_out_t;

	typedef struct packed {
		logic [7:0]  window_ms;
		logic [7:0]  min_pulses;
		logic [7:0]  max_pulses;
		logic [15:0] high_timeout_ms;
	} opc_cfg_t;

endpackage

`default_nettype wire

### hdl/obstruction_pulse_classifier_unit.sv
// Top level of the obstruction pulse classifier: input register, config
// registers, classifier core and result register. Depends on opc_pkg, opc_core.
//
//   channel | signals                                  | direction
//   in      | in_valid, in_ready, in_item              | item in
//   out     | out_valid, out_ready, out_item           | result out
//   cfg     | cfg_we, cfg_index, cfg_data              | register write
//
// Each item passes through the input register and then the result register: the accepting edge
// loads the input register, and a later edge on which the item advances commits the core state and loads
// the result register. One item is accepted per cycle while the output is not stalled.
// Reset clears state and valids and sets the config registers to their defaults at once.
// A stalled output holds the result and backs up through the input register.
`timescale 1ns / 1ps
`default_nettype none

module obstruction_pulse_classifier_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire opc_pkg::opc_in_t                in_item,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output opc_pkg::opc_out_t                    out_item,
	input  wire logic                            cfg_we,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [opc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import opc_pkg::*;

	opc_in_t  item_s1;
	logic     valid_s1;
	opc_out_t out_item_q;
	logic     out_valid_q;
	opc_cfg_t cfg_q;
	opc_out_t result;
	logic     advance;

	// Move the stage-one item when the result register is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ms       <= RST_WINDOW_MS;
			cfg_q.min_pulses      <= RST_MIN_PULSES;
			cfg_q.max_pulses      <= RST_MAX_PULSES;
			cfg_q.high_timeout_ms <= RST_HIGH_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_MS:    cfg_q.window_ms       <= cfg_data[7:0];
				REG_MIN_PULSES:   cfg_q.min_pulses      <= cfg_data[7:0];
				REG_MAX_PULSES:   cfg_q.max_pulses      <= cfg_data[7:0];
				REG_HIGH_TIMEOUT: cfg_q.high_timeout_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	opc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.result  (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

### hdl/opc_core.sv
// Classifier state and per-item update: window age, high age, pulse count.
// Depends on opc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module opc_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire opc_pkg::opc_in_t  item,
	input  wire opc_pkg::opc_cfg_t cfg,
	output opc_pkg::opc_out_t      result
);
	import opc_pkg::*;

	// Ages are kept as differences from the current time, so no clock value is stored
	logic [31:0] win_age_q;
	logic [31:0] high_age_q;
	logic [7:0]  count_q;
	logic [1:0]  class_q;

	logic [31:0] win_age_d;
	logic [31:0] high_age_d;
	logic [7:0]  count_d;
	logic [1:0]  class_d;
	logic [31:0] win_age_inc;
	logic [31:0] high_age_inc;
	logic        in_range;
	logic        obstructed;

	assign win_age_inc  = win_age_q + 32'd1;
	assign high_age_inc = high_age_q + 32'd1;

	// Judge the window as of the tick that closes it
	assign in_range   = (count_q >= cfg.min_pulses) && (count_q <= cfg.max_pulses);
	assign obstructed = (count_q == 8'd0) && item.line_level &&
		(high_age_inc > {16'd0, cfg.high_timeout_ms});

	// Next state for one item
	always_comb begin
		win_age_d  = win_age_q;
		high_age_d = high_age_q;
		count_d    = count_q;
		class_d    = class_q;
		unique case (item.func)
			FUNC_TICK: begin
				win_age_d  = win_age_inc;
				high_age_d = high_age_inc;
				if (win_age_inc > {24'd0, cfg.window_ms}) begin
					win_age_d = 32'd0;
					count_d   = 8'd0;
					if (in_range) begin
						class_d = STAT_CLEAR;
					end else if (obstructed) begin
						class_d = STAT_OBSTRUCTED;
					end
				end
			end
			FUNC_ROSE: begin
				high_age_d = 32'd0;
			end
			FUNC_FELL: begin
				if (count_q != PULSE_MAX) begin
					count_d = count_q + 8'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.beam_status    = class_d;
	assign result.status_changed = (class_d != class_q);

	// Commit the state when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_age_q  <= 32'd0;
			high_age_q <= 32'd0;
			count_q    <= 8'd0;
			class_q    <= STAT_UNKNOWN;
		end else if (advance) begin
			win_age_q  <= win_age_d;
			high_age_q <= high_age_d;
			count_q    <= count_d;
			class_q    <= class_d;
		end
	end

endmodule

`default_nettype wire

### hdl/opc_checker.sv
// Port-level checks of the obstruction pulse classifier and their binding.
// Depends on opc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module opc_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_ready,
	input  wire logic              out_valid,
	input  wire logic              out_ready,
	input  wire opc_pkg::opc_out_t out_item
);
	import opc_pkg::*;

	logic [1:0] last_status_q;

	// Track the status of the last delivered item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_status_q <= STAT_UNKNOWN;
		end else if (out_valid && out_ready) begin
			last_status_q <= out_item.beam_status;
		end
	end

	`ASSERT_HS(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_item))
	`ASSERT_CLK(a_changed_flag, clk, arst_n, out_valid |-> (out_item.status_changed == (out_item.beam_status != last_status_q)))
	`ASSERT_CLK(a_no_unknown_again, clk, arst_n, out_valid && (last_status_q != STAT_UNKNOWN) |-> (out_item.beam_status != STAT_UNKNOWN))
	`ASSERT_CLK(a_status_code, clk, arst_n, out_valid |-> (out_item.beam_status <= STAT_UNKNOWN))

	// Input side is ready whenever no result waits at the output
	`ASSERT_HS(a_in_open, clk, arst_n, !out_valid |-> in_ready)

endmodule

bind obstruction_pulse_classifier_unit opc_checker u_opc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

`default_nettype wire
